[hdl/swdd_pkg.sv]
// Shared types, codes and constants for the swipe direction detector.
// No dependencies; the core, front and back files in hdl/ refer to this package by scoped names.
`default_nettype none

package swdd_pkg;

  // Default parameter values
  localparam int COORD_BITS_DEF      = 12;
  localparam int ANGLE_FRAC_BITS_DEF = 6;
  localparam int CORDIC_STEPS_DEF    = 16;

  // Fixed field widths
  localparam int ACTION_W   = 2;
  localparam int VERDICT_W  = 2;
  localparam int ANGLE_W    = 15;
  localparam int MIN_DIST_W = 12;
  localparam int DEBOUNCE_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 2;

  // Register reset values
  localparam logic [MIN_DIST_W-1:0] MIN_DIST_RST = 12'd16;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd100;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_DISTANCE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_MS  = 2'd1;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_PRESS   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd2;

  // CORDIC and queue constants
  localparam int PRE_SHIFT   = 16;
  localparam int TBL_IDX_W   = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_IGNORE = 2'd0,
    VERDICT_MAYBE  = 2'd1,
    VERDICT_CANCEL = 2'd2,
    VERDICT_FINISH = 2'd3
  } verdict_t;

  // Control part of one job handed from front to back
  typedef struct packed {
    verdict_t verdict;
    logic     run_cordic;
  } job_ctrl_t;

  localparam int JOB_CTRL_W = $bits(job_ctrl_t);

  // atan(2^-i) as a fraction of a full turn, scaled by 2^32
  function automatic logic [31:0] atan_turn(input logic [TBL_IDX_W-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/swipe_direction_detector_core.sv]
// Flow: an accepted item is written to the job queue; the back end pops a job only in
// S_IDLE, so it finishes one job before taking the next, and a finish with motion passes
// through S_ITER, S_MUL and S_RND before S_EMIT loads the output register.
// Throughput: one CORDIC iteration per cycle; the front end takes an item each cycle the
// queue has room. Reset: synchronous, active high; clears start point, ms counter, queue,
// back end state and out_valid, and loads min_distance = 16 and debounce_ms = 100.
`default_nettype none

module swipe_direction_detector_core #(
  parameter int COORD_BITS      = swdd_pkg::COORD_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = swdd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = swdd_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [swdd_pkg::ACTION_W-1:0]   action,
  input  wire logic [COORD_BITS-1:0]           pos_x,
  input  wire logic [COORD_BITS-1:0]           pos_y,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [swdd_pkg::VERDICT_W-1:0]       verdict,
  output logic [swdd_pkg::ANGLE_W-1:0]         angle,
  input  wire logic                            cfg_we,
  input  wire logic [swdd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [swdd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DX_W  = COORD_BITS + 1;
  localparam int JOB_W = swdd_pkg::JOB_CTRL_W + 2 * DX_W;

  logic                       push;
  logic                       full;
  logic                       pop;
  logic                       avail;
  swdd_pkg::job_ctrl_t        f_ctrl;
  logic signed [COORD_BITS:0] f_dx;
  logic signed [COORD_BITS:0] f_dy;
  logic [JOB_W-1:0]           q_in;
  logic [JOB_W-1:0]           q_out;
  swdd_pkg::job_ctrl_t        b_ctrl;
  logic signed [COORD_BITS:0] b_dx;
  logic signed [COORD_BITS:0] b_dy;

  swdd_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .job_full  (full),
    .job_push  (push),
    .job_ctrl  (f_ctrl),
    .job_dx    (f_dx),
    .job_dy    (f_dy)
  );

  assign q_in = {f_ctrl, f_dx, f_dy};

  swdd_queue #(
    .DATA_W (JOB_W),
    .DEPTH  (swdd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (q_in),
    .full      (full),
    .pop       (pop),
    .not_empty (avail),
    .pop_data  (q_out)
  );

  assign b_ctrl = q_out[JOB_W-1 -: swdd_pkg::JOB_CTRL_W];
  assign b_dx   = q_out[2*DX_W-1 -: DX_W];
  assign b_dy   = q_out[DX_W-1:0];

  swdd_back #(
    .COORD_BITS      (COORD_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .CORDIC_STEPS    (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_avail (avail),
    .job_ctrl  (b_ctrl),
    .job_dx    (b_dx),
    .job_dy    (b_dy),
    .job_pop   (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .verdict   (verdict),
    .angle     (angle)
  );

endmodule

`default_nettype wire

[hdl/swdd_front.sv]
// Front end: takes items, holds config, start point and ms counter, classifies events.
// Uses swdd_pkg; pushes one job per item toward the back end queue.
`default_nettype none

module swdd_front #(
  parameter int COORD_BITS = swdd_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [swdd_pkg::ACTION_W-1:0]       action,
  input  wire logic [COORD_BITS-1:0]               pos_x,
  input  wire logic [COORD_BITS-1:0]               pos_y,
  input  wire logic                                cfg_we,
  input  wire logic [swdd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [swdd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                                job_full,
  output logic                                     job_push,
  output swdd_pkg::job_ctrl_t                      job_ctrl,
  output logic signed [COORD_BITS:0]               job_dx,
  output logic signed [COORD_BITS:0]               job_dy
);

  localparam int CMP_W = (COORD_BITS > swdd_pkg::MIN_DIST_W) ? COORD_BITS
                                                             : swdd_pkg::MIN_DIST_W;

  logic [swdd_pkg::MIN_DIST_W-1:0] min_distance;
  logic [swdd_pkg::DEBOUNCE_W-1:0] debounce_ms;
  logic [COORD_BITS-1:0]           start_x;
  logic [COORD_BITS-1:0]           start_y;
  logic [swdd_pkg::DEBOUNCE_W-1:0] elapsed_ms;

  logic [COORD_BITS-1:0]           start_x_next;
  logic [COORD_BITS-1:0]           start_y_next;
  logic [swdd_pkg::DEBOUNCE_W-1:0] elapsed_ms_next;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [COORD_BITS:0] dx_neg;
  logic signed [COORD_BITS:0] dy_neg;
  logic [COORD_BITS-1:0]      ax;
  logic [COORD_BITS-1:0]      ay;
  logic                       too_short;

  assign in_ready = !job_full;
  assign job_push = in_valid && in_ready;

  assign dx     = $signed({1'b0, pos_x}) - $signed({1'b0, start_x});
  assign dy     = $signed({1'b0, pos_y}) - $signed({1'b0, start_y});
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign ax     = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
  assign ay     = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
  assign too_short = (CMP_W'(ax) < CMP_W'(min_distance)) &&
                     (CMP_W'(ay) < CMP_W'(min_distance));

  assign job_dx = dx;
  assign job_dy = dy;

  always_comb begin
    start_x_next        = start_x;
    start_y_next        = start_y;
    elapsed_ms_next     = elapsed_ms;
    job_ctrl.verdict    = swdd_pkg::VERDICT_IGNORE;
    job_ctrl.run_cordic = 1'b0;
    unique case (action)
      swdd_pkg::ACT_PRESS: begin
        start_x_next     = pos_x;
        start_y_next     = pos_y;
        job_ctrl.verdict = swdd_pkg::VERDICT_MAYBE;
      end
      swdd_pkg::ACT_RELEASE: begin
        start_x_next = '0;
        start_y_next = '0;
        if (too_short) begin
          job_ctrl.verdict = swdd_pkg::VERDICT_CANCEL;
        end else begin
          // restart the counter on every release that travels far enough
          elapsed_ms_next = '0;
          if (elapsed_ms < debounce_ms) begin
            job_ctrl.verdict = swdd_pkg::VERDICT_CANCEL;
          end else begin
            job_ctrl.verdict    = swdd_pkg::VERDICT_FINISH;
            // no displacement: angle stays zero, skip the CORDIC
            job_ctrl.run_cordic = (dx != '0) || (dy != '0);
          end
        end
      end
      swdd_pkg::ACT_TICK: begin
        if (elapsed_ms != '1) begin
          elapsed_ms_next = elapsed_ms + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= swdd_pkg::MIN_DIST_RST;
      debounce_ms  <= swdd_pkg::DEBOUNCE_RST;
      start_x      <= '0;
      start_y      <= '0;
      elapsed_ms   <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == swdd_pkg::REG_MIN_DISTANCE) begin
          min_distance <= cfg_wdata[swdd_pkg::MIN_DIST_W-1:0];
        end else if (cfg_addr == swdd_pkg::REG_DEBOUNCE_MS) begin
          debounce_ms <= cfg_wdata[swdd_pkg::DEBOUNCE_W-1:0];
        end
      end
      if (job_push) begin
        start_x    <= start_x_next;
        start_y    <= start_y_next;
        elapsed_ms <= elapsed_ms_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && job_push && (action == swdd_pkg::ACT_RELEASE)) begin
      assert (job_ctrl.verdict == swdd_pkg::VERDICT_CANCEL ||
              job_ctrl.verdict == swdd_pkg::VERDICT_FINISH)
        else $error("release must cancel or finish");
    end
  end

  a_run_only_on_finish: assert property (@(posedge clk) disable iff (rst)
    job_ctrl.run_cordic |-> (job_ctrl.verdict == swdd_pkg::VERDICT_FINISH))
    else $error("CORDIC requested for a non-finish item");

  a_release_clears_start: assert property (@(posedge clk) disable iff (rst)
    (job_push && action == swdd_pkg::ACT_RELEASE) |=> (start_x == '0 && start_y == '0))
    else $error("start point not cleared after release");

  a_counter_saturates: assert property (@(posedge clk) disable iff (rst)
    (elapsed_ms == '1 && !(job_push && action == swdd_pkg::ACT_RELEASE)) |=>
      (elapsed_ms == '1))
    else $error("elapsed counter wrapped");

endmodule

`default_nettype wire

[hdl/swdd_queue.sv]
// Small FIFO of jobs between front and back ends.
// Uses swdd_pkg only through its parameters at instantiation; DEPTH is a power of two.
`default_nettype none

module swdd_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output logic [DATA_W-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty))
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

[hdl/swdd_back.sv]
// Back end: iterative CORDIC in vectoring mode, angle scaling and the output register.
// Uses swdd_pkg (verdict codes, job control struct, arctangent table).
`default_nettype none

module swdd_back #(
  parameter int COORD_BITS      = swdd_pkg::COORD_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = swdd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = swdd_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               job_avail,
  input  wire swdd_pkg::job_ctrl_t                job_ctrl,
  input  wire logic signed [COORD_BITS:0]         job_dx,
  input  wire logic signed [COORD_BITS:0]         job_dy,
  output logic                                    job_pop,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [swdd_pkg::VERDICT_W-1:0]          verdict,
  output logic [swdd_pkg::ANGLE_W-1:0]            angle
);

  // datapath width: coordinate, pre-shift, sign and CORDIC growth
  localparam int W       = COORD_BITS + swdd_pkg::PRE_SHIFT + 3;
  localparam int EXT_W   = W - COORD_BITS - 1 - swdd_pkg::PRE_SHIFT;
  localparam int STEP_W  = $clog2(CORDIC_STEPS);
  localparam int FULL    = 360 * (2 ** ANGLE_FRAC_BITS);
  localparam int FULL_W  = $clog2(FULL + 1);
  localparam int PW      = 32 + FULL_W;
  localparam int AW      = (FULL_W > swdd_pkg::ANGLE_W) ? FULL_W : swdd_pkg::ANGLE_W;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [PW-1:0]     FULL_P    = PW'(FULL);
  localparam logic [PW-1:0]     ROUND_P   = PW'(swdd_pkg::HALF_TURN);
  localparam logic [FULL_W-1:0] FULL_S    = FULL_W'(FULL);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ITER,
    S_MUL,
    S_RND,
    S_EMIT
  } state_t;

  state_t                   state;
  logic signed [W-1:0]      x;
  logic signed [W-1:0]      y;
  logic [31:0]              z;
  logic [STEP_W-1:0]        step;
  logic [PW-1:0]            prod;
  swdd_pkg::verdict_t       res_verdict;
  logic [swdd_pkg::ANGLE_W-1:0] res_angle;

  logic signed [COORD_BITS:0] sx;
  logic signed [COORD_BITS:0] sy;
  logic signed [W-1:0]        x_init;
  logic signed [W-1:0]        y_init;
  logic signed [W-1:0]        x_sh;
  logic signed [W-1:0]        y_sh;
  logic                       y_pos;
  logic [31:0]                step_turn;
  logic [PW-1:0]              rsum;
  logic [FULL_W-1:0]          scaled;
  logic [FULL_W-1:0]          wrapped;
  logic [AW-1:0]              angle_ext;
  logic                       emit;

  assign job_pop = (state == S_IDLE) && job_avail;

  // load the output register once it is free or being drained
  assign emit = (state == S_EMIT) && (!out_valid || out_ready);

  // rotate into the right half plane: x = dx, y = -dy, negated when dx < 0
  assign sx     = job_dx[COORD_BITS] ? -job_dx : job_dx;
  assign sy     = job_dx[COORD_BITS] ? job_dy : -job_dy;
  assign x_init = {{EXT_W{sx[COORD_BITS]}}, sx, {swdd_pkg::PRE_SHIFT{1'b0}}};
  assign y_init = {{EXT_W{sy[COORD_BITS]}}, sy, {swdd_pkg::PRE_SHIFT{1'b0}}};

  assign x_sh      = x >>> step;
  assign y_sh      = y >>> step;
  assign y_pos     = !y[W-1] && (y != '0);
  assign step_turn = swdd_pkg::atan_turn(swdd_pkg::TBL_IDX_W'(step));

  assign rsum      = prod + ROUND_P;
  assign scaled    = rsum[PW-1:32];
  assign wrapped   = (scaled >= FULL_S) ? (scaled - FULL_S) : scaled;
  assign angle_ext = AW'(wrapped);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_avail) begin
            res_verdict <= job_ctrl.verdict;
            res_angle   <= '0;
            x           <= x_init;
            y           <= y_init;
            z           <= job_dx[COORD_BITS] ? swdd_pkg::HALF_TURN : '0;
            step        <= '0;
            state       <= job_ctrl.run_cordic ? S_ITER : S_EMIT;
          end
        end
        S_ITER: begin
          if (y_pos) begin
            x <= x + y_sh;
            y <= y - x_sh;
            z <= z + step_turn;
          end else begin
            x <= x - y_sh;
            y <= y + x_sh;
            z <= z - step_turn;
          end
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PW'(z) * FULL_P;
          state <= S_RND;
        end
        S_RND: begin
          res_angle <= angle_ext[swdd_pkg::ANGLE_W-1:0];
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            verdict <= res_verdict;
            angle   <= res_angle;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_angle_only_on_finish: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict != swdd_pkg::VERDICT_FINISH) |-> (angle == '0))
    else $error("nonzero angle on a non-finish result");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> (state == S_ITER || state == S_EMIT))
    else $error("job popped without starting work");

  a_emit_fills_output: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("result not placed in output register");

endmodule

`default_nettype wire

[verif/tb_swipe_direction_detector_core.sv]
// Self-checking testbench for swipe_direction_detector_core: touch items go in, verdicts
// and swipe angles are predicted by a scoreboard class and compared as results come out.
// Depends on swdd_pkg and the core; needs no files or arguments.

module tb_swipe_direction_detector_core;
  import swdd_pkg::*;

  localparam logic [ACTION_W-1:0]   ACT_UNKNOWN   = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI = 2'd3;
  localparam int SETTLE_CYCLES = 30;
  localparam int FULL_TURN     = 360 << ANGLE_FRAC_BITS_DEF;
  localparam int MAX_PRINTED   = 40;

  typedef struct {
    verdict_t           verdict;
    logic [ANGLE_W-1:0] angle;
  } swipe_result_t;

  class verdict_scoreboard;
    logic [MIN_DIST_W-1:0] min_dist;
    logic [DEBOUNCE_W-1:0] debounce;
    logic [11:0]           start_x;
    logic [11:0]           start_y;
    logic [15:0]           elapsed;
    logic [31:0]           turn_tbl[24];
    swipe_result_t         expected_verdicts[$];
    int                    errors;
    int                    checked;

    function new();
      // atan(2^-i) in units of 2^-32 turn
      turn_tbl = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                   32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                   32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                   32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                   32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                   32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      min_dist = 12'd16;
      debounce = 16'd100;
      start_x  = '0;
      start_y  = '0;
      elapsed  = '0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void set_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MIN_DISTANCE: min_dist = data[MIN_DIST_W-1:0];
        REG_DEBOUNCE_MS:  debounce = data;
        default: ;
      endcase
    endfunction

    // Vectoring CORDIC on atan2(-dy, dx), angle in 1/64 degree over [0,360)
    function logic [ANGLE_W-1:0] swipe_angle_64th(input longint dx, input longint dy);
      longint      x;
      longint      y;
      longint      xs;
      longint      ys;
      logic [31:0] z;
      logic [63:0] scaled;
      int          i;
      if (dx == 0 && dy == 0) return '0;
      x = dx * 65536;
      y = -dy * 65536;
      z = '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = HALF_TURN;
      end
      for (i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + turn_tbl[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - turn_tbl[i];
        end
      end
      scaled = (64'(z) * 64'(FULL_TURN) + 64'h8000_0000) >> 32;
      if (scaled >= 64'(FULL_TURN)) scaled = scaled - 64'(FULL_TURN);
      return scaled[ANGLE_W-1:0];
    endfunction

    function void predict_touch(input logic [ACTION_W-1:0] act, input logic [11:0] px,
                                input logic [11:0] py);
      swipe_result_t res;
      longint        dx;
      longint        dy;
      longint        ax;
      longint        ay;
      logic [15:0]   ms;
      res.verdict = VERDICT_IGNORE;
      res.angle   = '0;
      case (act)
        ACT_PRESS: begin
          start_x     = px;
          start_y     = py;
          res.verdict = VERDICT_MAYBE;
        end
        ACT_RELEASE: begin
          dx = longint'(px) - longint'(start_x);
          dy = longint'(py) - longint'(start_y);
          ax = (dx < 0) ? -dx : dx;
          ay = (dy < 0) ? -dy : dy;
          if (ax < longint'(min_dist) && ay < longint'(min_dist)) begin
            res.verdict = VERDICT_CANCEL;
          end else begin
            ms      = elapsed;
            elapsed = '0;
            if (ms < debounce) begin
              res.verdict = VERDICT_CANCEL;
            end else begin
              res.verdict = VERDICT_FINISH;
              res.angle   = swipe_angle_64th(dx, dy);
            end
          end
          start_x = '0;
          start_y = '0;
        end
        ACT_TICK: begin
          if (elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
        end
        default: ;
      endcase
      expected_verdicts.push_back(res);
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    task report(input string what);
      if (errors < MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(input logic [VERDICT_W-1:0] got_v, input logic [ANGLE_W-1:0] got_a);
      swipe_result_t want;
      if (expected_verdicts.size() == 0) begin
        report($sformatf("result verdict=%0d angle=%0d with nothing expected", got_v, got_a));
        return;
      end
      want = expected_verdicts.pop_front();
      if (got_v !== want.verdict)
        report($sformatf("result %0d verdict %0d, expected %s", checked, got_v,
                         want.verdict.name()));
      if (got_a !== want.angle)
        report($sformatf("result %0d angle %0d, expected %0d", checked, got_a, want.angle));
      checked++;
    endtask

    task flush_leftovers();
      while (expected_verdicts.size() != 0) begin
        report($sformatf("expected verdict %s never arrived",
                         expected_verdicts[0].verdict.name()));
        void'(expected_verdicts.pop_front());
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [ACTION_W-1:0]   action;
  logic [11:0]           pos_x;
  logic [11:0]           pos_y;
  logic                  out_valid;
  logic                  out_ready;
  logic [VERDICT_W-1:0]  verdict;
  logic [ANGLE_W-1:0]    angle;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  verdict_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_left;
  int items_sent;
  int settings_used;

  swipe_direction_detector_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .verdict   (verdict),
    .angle     (angle),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_left > 0) begin
        out_ready <= 1'b0;
        recv_hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(verdict, angle);
  end

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [11:0] px,
                           input logic [11:0] py);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    pos_x    <= px;
    pos_y    <= py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_touch(act, px, py);
    items_sent++;
  endtask

  // Drop valid and hold until every expected result is back and the core is quiet
  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  function automatic logic [11:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return 12'($urandom);
  endfunction

  task automatic random_gesture();
    logic [11:0] sx;
    logic [11:0] sy;
    logic [11:0] ex;
    logic [11:0] ey;
    int          kind;
    int          shape;
    int          span;
    int          n_ticks;
    kind  = $urandom_range(99);
    shape = $urandom_range(9);
    sx    = pick_coord();
    sy    = pick_coord();
    span  = int'(sb.min_dist) + 2;
    if (shape < 4) begin
      // land near the distance threshold
      ex = sx + 12'($urandom_range(2 * span) - span);
      ey = sy + 12'($urandom_range(2 * span) - span);
    end else if (shape < 6) begin
      ex = pick_coord();
      ey = pick_coord();
    end else if (shape == 6) begin
      ex = pick_coord();
      ey = sy;
    end else if (shape == 7) begin
      ex = sx;
      ey = pick_coord();
    end else begin
      span = $urandom_range(1, 2047);
      ex   = sx + 12'(span);
      ey   = $urandom_range(1) ? sy + 12'(span) : sy - 12'(span);
    end
    if (kind < 70) begin
      send_item(ACT_PRESS, sx, sy);
      n_ticks = (sb.debounce <= 20) ? $urandom_range(int'(sb.debounce) + 3) : $urandom_range(3);
      repeat (n_ticks) send_item(ACT_TICK, 12'($urandom), 12'($urandom));
      send_item(ACT_RELEASE, ex, ey);
    end else if (kind < 80) begin
      send_item(ACT_RELEASE, ex, ey);
    end else if (kind < 87) begin
      send_item(ACT_UNKNOWN, pick_coord(), pick_coord());
    end else if (kind < 93) begin
      send_item(ACT_PRESS, pick_coord(), pick_coord());
      send_item(ACT_PRESS, sx, sy);
      send_item(ACT_RELEASE, ex, ey);
    end else begin
      repeat ($urandom_range(1, 6)) send_item(ACT_TICK, 12'($urandom), 12'($urandom));
    end
  endtask

  task automatic run_setting(input logic [11:0] min_d, input logic [15:0] deb, input int n_items);
    logic [3:0] junk;
    int         stop_at;
    junk = 4'($urandom);
    drain_and_settle();
    // upper data bits must be ignored for the 12-bit register
    write_reg(REG_MIN_DISTANCE, {junk, min_d});
    write_reg(REG_DEBOUNCE_MS, deb);
    settings_used++;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) random_gesture();
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    action         = ACT_PRESS;
    pos_x          = '0;
    pos_y          = '0;
    cfg_we         = 1'b0;
    cfg_addr       = REG_MIN_DISTANCE;
    cfg_wdata      = '0;
    send_idle_pct  = 33;
    recv_idle_pct  = 82;
    recv_hold_left = 0;
    items_sent     = 0;
    settings_used  = 1;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: release without press, unknown action, debounce cancel
    send_item(ACT_RELEASE, 12'd5, 12'd5);
    send_item(ACT_UNKNOWN, 12'hFFF, 12'hFFF);
    send_item(ACT_TICK, 12'hFFF, 12'h000);
    send_item(ACT_PRESS, 12'hFFF, 12'hFFF);
    send_item(ACT_RELEASE, 12'h000, 12'h000);

    drain_and_settle();
    write_reg(REG_MIN_DISTANCE, 16'd0);
    write_reg(REG_DEBOUNCE_MS, 16'd0);
    write_reg(REG_UNUSED_LO, 16'hFFFF);
    write_reg(REG_UNUSED_HI, 16'h0000);
    settings_used++;
    // zero displacement, then release from the cleared start point
    send_item(ACT_PRESS, 12'd1234, 12'd2345);
    send_item(ACT_RELEASE, 12'd1234, 12'd2345);
    send_item(ACT_RELEASE, 12'd0, 12'd0);
    // compass points at full reach, two diagonals and a hair under a full turn
    send_item(ACT_PRESS, 12'd0, 12'd0);
    send_item(ACT_RELEASE, 12'hFFF, 12'd0);
    send_item(ACT_PRESS, 12'd0, 12'hFFF);
    send_item(ACT_RELEASE, 12'd0, 12'd0);
    send_item(ACT_PRESS, 12'hFFF, 12'd0);
    send_item(ACT_RELEASE, 12'd0, 12'd0);
    send_item(ACT_PRESS, 12'd0, 12'd0);
    send_item(ACT_RELEASE, 12'd0, 12'hFFF);
    send_item(ACT_PRESS, 12'd2048, 12'd2048);
    send_item(ACT_RELEASE, 12'd2047, 12'd2049);
    send_item(ACT_PRESS, 12'd0, 12'hFFF);
    send_item(ACT_RELEASE, 12'hFFF, 12'd0);
    send_item(ACT_PRESS, 12'd0, 12'd0);
    send_item(ACT_RELEASE, 12'hFFF, 12'd1);

    drain_and_settle();
    write_reg(REG_MIN_DISTANCE, 16'h0FFF);
    write_reg(REG_DEBOUNCE_MS, 16'd2);
    settings_used++;
    send_item(ACT_PRESS, 12'd0, 12'd0);
    send_item(ACT_TICK, 12'd0, 12'd0);
    send_item(ACT_TICK, 12'hFFF, 12'hFFF);
    send_item(ACT_RELEASE, 12'hFFF, 12'hFFE);
    send_item(ACT_PRESS, 12'd1, 12'd1);
    send_item(ACT_RELEASE, 12'hFFF, 12'hFFF);

    run_setting(12'd16, 16'd4, 55);
    recv_hold_left = 400;
    repeat (8) random_gesture();
    drain_and_settle();
    repeat (4) random_gesture();
    run_setting(12'd0, 16'd0, 55);
    run_setting(12'($urandom_range(1, 200)), 16'($urandom_range(1, 8)), 55);

    send_idle_pct = 82;
    recv_idle_pct = 33;
    run_setting(12'hFFF, 16'd2, 55);
    run_setting(12'd3, 16'd1, 55);
    run_setting(12'd64, 16'd10, 55);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_setting(12'd1, 16'd0, 55);
    run_setting(12'($urandom_range(300)), 16'($urandom_range(6)), 55);

    drain_and_settle();
    sb.flush_leftovers();
    $display("Run covered %0d touch items and %0d checked results across %0d register settings,",
             items_sent, sb.checked, settings_used);
    $display("three idle patterns, a long output stall and full-queue input backpressure.");
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
